// ----- design/ttl_pkg.sv -----
// ttl_pkg: constants, curve tables and per-type lookups for the thermistor linearizer.
// Shared by ttl_div, ttl_core and thermistor_table_linearizer_top; no dependencies.
package ttl_pkg;

	localparam int RAW_W     = 12;
	localparam int OUT_W     = 13;
	localparam int TYPE_W    = 4;
	localparam int S_TDATA_W = ((RAW_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [TYPE_W-1:0] TYPE_RESET = TYPE_W'(3);

	localparam int SEGMENTS  = 16;
	localparam int CURVES    = 5;
	localparam int NUM_TYPES = 10;

	localparam int CRV_W  = 8;                 // stored curve point, before x4
	localparam int PT_W   = CRV_W + 2;         // curve point in ADC counts
	localparam int IDX_W  = $clog2(SEGMENTS + 1);
	localparam int CI_W   = (CURVES > 1) ? $clog2(CURVES) : 1;
	localparam int TI_W   = $clog2(NUM_TYPES);

	localparam int PCT      = 100;
	localparam int STEP_MAX = 214;
	localparam int STEP_W   = $clog2(STEP_MAX + 1);
	localparam int Q1_W     = $clog2(PCT + 1);               // fraction quotient
	localparam int QUO_W    = Q1_W;
	localparam int DEN_W    = PT_W;
	localparam int CNT_W    = $clog2(QUO_W + 1);

	// step x fraction, divided by 100 as multiply by reciprocal and shift;
	// exact for every product up to STEP_MAX x PCT
	localparam int Y_W     = $clog2(STEP_MAX * PCT + 1);
	localparam int RCP_SH  = 19;
	localparam int RCP_MUL = (1 << RCP_SH) / PCT + 1;
	localparam int RCP_W   = $clog2(RCP_MUL + 1);

	// shared multiplier operands
	localparam int MA_W = Y_W;
	localparam int MB_W = RCP_W;
	localparam int MP_W = MA_W + MB_W;

	// Descending curves, point 0 first
	localparam logic [0:SEGMENTS][CRV_W-1:0] CRV_A = {
		8'd233, 8'd211, 8'd179, 8'd141, 8'd103, 8'd71, 8'd48, 8'd32,
		8'd21,  8'd14,  8'd10,  8'd7,   8'd5,   8'd4,  8'd3,  8'd2,  8'd1 };
	localparam logic [0:SEGMENTS][CRV_W-1:0] CRV_B = {
		8'd246, 8'd238, 8'd227, 8'd211, 8'd191, 8'd167, 8'd141, 8'd115,
		8'd92,  8'd72,  8'd55,  8'd42,  8'd33,  8'd25,  8'd19,  8'd15, 8'd12 };
	localparam logic [0:SEGMENTS][CRV_W-1:0] CRV_C = {
		8'd233, 8'd215, 8'd190, 8'd160, 8'd127, 8'd96, 8'd70, 8'd50,
		8'd35,  8'd25,  8'd18,  8'd13,  8'd9,   8'd7,  8'd5,  8'd4,  8'd3 };

	// Request into the shared divider
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] iters;
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [DEN_W-1:0] den;
	} ttl_div_req_t;

	// Handshake controls from top into the sequencer
	typedef struct packed {
		logic start;
		logic res_ready;
	} ttl_ctl_t;

	// Sequencer status back to top
	typedef struct packed {
		logic idle;
		logic res_valid;
	} ttl_sts_t;

	// Out-of-range types fold onto 1 or 10
	function automatic logic [TI_W-1:0] type_idx(input logic [TYPE_W-1:0] t);
		logic [TYPE_W-1:0] tc;
		if (t == '0) begin
			tc = TYPE_W'(1);
		end else if (t > TYPE_W'(NUM_TYPES)) begin
			tc = TYPE_W'(NUM_TYPES);
		end else begin
			tc = t;
		end
		return TI_W'(tc - TYPE_W'(1));
	endfunction

	function automatic logic [CI_W-1:0] curve_of(input logic [TI_W-1:0] ti);
		logic [TI_W-1:0] c;
		c = ti >> 1;
		if (c >= TI_W'(CURVES)) begin
			c = TI_W'(CURVES - 1);
		end
		return CI_W'(c);
	endfunction

	function automatic logic [PT_W-1:0] curve_pt(input logic [CI_W-1:0] ci,
			input logic [IDX_W-1:0] i);
		logic [CRV_W-1:0] b;
		b = '0;
		if (i <= IDX_W'(SEGMENTS)) begin
			case (ci)
				CI_W'(0): b = CRV_A[i];
				CI_W'(2): b = CRV_C[i];
				default:  b = CRV_B[i];
			endcase
		end
		return {b, 2'b00};
	endfunction

	function automatic logic signed [OUT_W-1:0] lim_lo(input logic [TI_W-1:0] ti);
		logic signed [OUT_W-1:0] v;
		case (ti)
			TI_W'(8): v = OUT_W'(-500);
			TI_W'(9): v = OUT_W'(-580);
			default:  v = OUT_W'(-400);
		endcase
		return v;
	endfunction

	function automatic logic signed [OUT_W-1:0] lim_hi(input logic [TI_W-1:0] ti);
		logic signed [OUT_W-1:0] v;
		case (ti) inside
			TI_W'(0):                     v = OUT_W'(1500);
			TI_W'(1):                     v = OUT_W'(3020);
			TI_W'(2), TI_W'(4), TI_W'(6): v = OUT_W'(1200);
			TI_W'(8):                     v = OUT_W'(1100);
			TI_W'(9):                     v = OUT_W'(2300);
			default:                      v = OUT_W'(2480);
		endcase
		return v;
	endfunction

	function automatic logic [STEP_W-1:0] step_of(input logic [TI_W-1:0] ti);
		logic [STEP_W-1:0] v;
		case (ti) inside
			TI_W'(0):                               v = STEP_W'(119);
			TI_W'(1):                               v = STEP_W'(STEP_MAX);
			TI_W'(2), TI_W'(4), TI_W'(6), TI_W'(8): v = STEP_W'(PCT);
			default:                                v = STEP_W'(180);
		endcase
		return v;
	endfunction

endpackage

// ----- design/thermistor_table_linearizer_top.sv -----
// thermistor_table_linearizer_top: stream ports, sensor type register, output item register.
// Depends on ttl_pkg and ttl_core (which holds ttl_div).
//
// Converts one 12-bit scaled ADC count (larger is colder) into a signed temperature in
// tenths of a degree. sensor_type (1..10, reset 3; 0 reads as 1, above 10 as 10) picks one
// of three descending 17-point curves, a low and a high limit and a step size; it is
// sampled when an item is accepted and must be written only while the block is idle.
// Readings at or past either curve end give the matching limit without a search.
// Other readings go through a halving search from the middle point (one probe per cycle,
// at most five); a search that runs out gives 0. On a hit the segment fraction goes
// through the bit-serial divider (7 iterations), then one shared 15x13 multiplier forms
// step x segment and step x fraction and divides the latter by 100 through a reciprocal
// multiply. Readings strictly inside the last segment are never reached by the search
// and return 0. The block takes one item at a time (s_tready low while busy), but a
// finished result sits in the output register so the next item can be taken while
// the consumer stalls.
module thermistor_table_linearizer_top import ttl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] raw_reading, rest zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [12:0] temperature_tenths, rest zero
	input  logic                 cfg_we,
	input  logic [TYPE_W-1:0]    cfg_wdata
);

	logic [TYPE_W-1:0]       sensor_type_q;
	logic                    m_tvalid_q;
	logic [OUT_W-1:0]        m_res_q;

	ttl_ctl_t                ctl;
	ttl_sts_t                sts;
	logic signed [OUT_W-1:0] core_res;
	logic                    res_xfer;

	// sensor type register, write-only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_type_q <= TYPE_RESET;
		end else if (cfg_we) begin
			sensor_type_q <= cfg_wdata;
		end
	end

	// output slot is free when empty or being drained this cycle
	assign ctl.res_ready = !m_tvalid_q || m_tready;
	assign ctl.start     = s_tvalid && sts.idle;
	assign s_tready      = sts.idle;
	assign res_xfer      = sts.res_valid && ctl.res_ready;

	ttl_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.raw         (s_tdata[RAW_W-1:0]),
		.sensor_type (sensor_type_q),
		.sts         (sts),
		.res         (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_xfer) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_xfer) begin
			m_res_q <= core_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_res_q);

	// an accepted item leaves the block not ready in the cycle after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("block still ready after taking an item");

	// a finished result lands in the output register
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer |=> m_tvalid)
		else $error("finished result did not reach the output register");

	// every result lies within the widest limits of any sensor type
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_res_q) >= -580) && ($signed(m_res_q) <= 3020))
		else $error("temperature out of range");

endmodule

// ----- design/ttl_div.sv -----
// ttl_div: shared restoring divider, one quotient bit per cycle.
// Depends on ttl_pkg (widths, ttl_div_req_t).
module ttl_div import ttl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ttl_div_req_t     req,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic             ge;

	// partial remainder is always below the divisor, so one compare per bit
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = busy_q && (cnt_q == '0);
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.iters;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			quo_q <= req.quo;
			den_q <= req.den;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

endmodule

// ----- design/ttl_core.sv -----
// ttl_core: sequencer for clamp, halving search and interpolation arithmetic.
// Depends on ttl_pkg; drives one shared multiplier and the ttl_div unit.
module ttl_core import ttl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ttl_ctl_t                ctl,
	input  logic [RAW_W-1:0]        raw,
	input  logic [TYPE_W-1:0]       sensor_type,
	output ttl_sts_t                sts,
	output logic signed [OUT_W-1:0] res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_DIV1 = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_RCP  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]              state_q;
	logic [TI_W-1:0]         ti_q;
	logic [CI_W-1:0]         ci_q;
	logic [RAW_W-1:0]        raw_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        delta_q;
	logic [IDX_W-1:0]        seg_q;
	logic [PT_W-1:0]         diff_q;
	logic [PT_W-1:0]         wid_q;
	logic [QUO_W-1:0]        frac_q;
	logic [Y_W-1:0]          y_q;
	logic signed [OUT_W-1:0] res_q;

	logic [TI_W-1:0]         ti_in;
	logic [CI_W-1:0]         ci_in;
	logic [PT_W-1:0]         pt_first;
	logic [PT_W-1:0]         pt_last;
	logic [PT_W-1:0]         tb_i;
	logic [PT_W-1:0]         tb_p;
	logic                    hit;
	logic [IDX_W-1:0]        nd;
	logic signed [IDX_W+1:0] nxt;

	logic [MA_W-1:0]         mul_a;
	logic [MB_W-1:0]         mul_b;
	logic [MP_W-1:0]         mul_p;
	ttl_div_req_t            dreq;
	logic                    ddone;
	logic [QUO_W-1:0]        dquo;

	// end-point clamp uses the live register, captured at accept
	assign ti_in    = type_idx(sensor_type);
	assign ci_in    = curve_of(ti_in);
	assign pt_first = curve_pt(ci_in, '0);
	assign pt_last  = curve_pt(ci_in, IDX_W'(SEGMENTS));

	// bracket test at the current probe point
	assign tb_i = curve_pt(ci_q, idx_q);
	assign tb_p = curve_pt(ci_q, idx_q - IDX_W'(1));
	assign hit  = (idx_q >= IDX_W'(1)) && (idx_q <= IDX_W'(SEGMENTS))
		&& (raw_q >= RAW_W'(tb_i)) && (raw_q <= RAW_W'(tb_p));
	assign nd   = delta_q >> 1;
	assign nxt  = (raw_q < RAW_W'(tb_i))
		? ($signed({2'b00, idx_q}) + $signed({2'b00, nd}))
		: ($signed({2'b00, idx_q}) - $signed({2'b00, nd}));

	// shared multiplier: diff x 100, seg x step, frac x step, then x reciprocal of 100
	always_comb begin
		case (state_q)
			ST_DIV1: begin
				mul_a = MA_W'(seg_q);
				mul_b = MB_W'(step_of(ti_q));
			end
			ST_MUL2: begin
				mul_a = MA_W'(frac_q);
				mul_b = MB_W'(step_of(ti_q));
			end
			ST_RCP: begin
				mul_a = MA_W'(y_q);
				mul_b = MB_W'(RCP_MUL);
			end
			default: begin
				mul_a = MA_W'(diff_q);
				mul_b = MB_W'(PCT);
			end
		endcase
	end
	assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

	// divider load: high part seeds the remainder, low part shifts in
	always_comb begin
		dreq.start = (state_q == ST_MUL1);
		dreq.den   = wid_q;
		dreq.iters = CNT_W'(Q1_W);
		dreq.rem   = DEN_W'(mul_p >> Q1_W);
		dreq.quo   = mul_p[Q1_W-1:0];
	end

	ttl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (ddone),
		.quo    (dquo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						if ((raw <= RAW_W'(pt_last)) || (raw >= RAW_W'(pt_first))) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (hit) begin
						state_q <= ST_MUL1;
					end else if ((delta_q == '0) || (nxt <= 0) || (nxt >= SEGMENTS)) begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL1: state_q <= ST_DIV1;
				ST_DIV1: if (ddone) state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_RCP;
				ST_RCP:  state_q <= ST_DONE;
				ST_DONE: if (ctl.res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					ti_q    <= ti_in;
					ci_q    <= ci_in;
					raw_q   <= raw;
					idx_q   <= IDX_W'(SEGMENTS / 2);
					delta_q <= IDX_W'(SEGMENTS / 2);
					if (raw <= RAW_W'(pt_last)) begin
						res_q <= lim_hi(ti_in);
					end else begin
						res_q <= lim_lo(ti_in);
					end
				end
			end
			ST_SRCH: begin
				if (hit) begin
					seg_q  <= idx_q - IDX_W'(1);
					diff_q <= PT_W'(RAW_W'(tb_p) - raw_q);
					wid_q  <= tb_p - tb_i;
				end else if (delta_q == '0) begin
					res_q <= '0;                 // search ran out
				end else if (nxt <= 0) begin
					res_q <= lim_lo(ti_q);
				end else if (nxt >= SEGMENTS) begin
					res_q <= lim_hi(ti_q);
				end else begin
					idx_q   <= nxt[IDX_W-1:0];
					delta_q <= nd;
				end
			end
			ST_DIV1: begin
				// whole segments need no division: low limit plus step x seg
				if (ddone) begin
					frac_q <= dquo;
					res_q  <= lim_lo(ti_q) + $signed(OUT_W'(mul_p));
				end
			end
			ST_MUL2: begin
				y_q <= Y_W'(mul_p);
			end
			ST_RCP: begin
				res_q <= res_q + $signed(OUT_W'(mul_p >> RCP_SH));
			end
			default: ;
		endcase
	end

	assign sts.idle      = (state_q == ST_IDLE);
	assign sts.res_valid = (state_q == ST_DONE);
	assign res           = res_q;

endmodule
